### hw/rtl/frx_pkg.sv
// Shared types and constants for the delimited frame receiver.
// Used by the channel interfaces, the parser, the readout sequencer and the top level.
// No dependencies.
`default_nettype none

package frx_pkg;

  // Store geometry: default depth and the count width that covers the largest depth
  localparam int unsigned STORE_DEPTH_DEF = 64;
  localparam int unsigned STORE_DEPTH_MAX = 64;
  localparam int unsigned FILL_MAX_W      = $clog2(STORE_DEPTH_MAX + 1);

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Marker reset values
  localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'h24;
  localparam logic [BYTE_W-1:0] CHECK_CHAR_RST = 8'h2A;
  localparam logic [BYTE_W-1:0] END_CHAR_RST   = 8'h25;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DATA = 2'd0,
    ST_CSUM = 2'd1,
    ST_LEN  = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CHAR = 2'd0,
    REG_CHECK_CHAR = 2'd1,
    REG_END_CHAR   = 2'd2
  } cfg_reg_t;

  // Readout sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_LENCHK,
    S_XOR,
    S_CMP,
    S_RD,
    S_OUT,
    S_ERR
  } seq_state_t;

  // Frame-complete request from the parser to the sequencer
  typedef struct packed {
    logic                  valid;
    logic [FILL_MAX_W-1:0] fill;
  } frame_req_t;

endpackage

`default_nettype wire

### hw/rtl/frx_if.sv
// Valid/ready channel interfaces for received bytes and for result items.
// Depends on frx_pkg for field widths.
`default_nettype none

interface frx_in_if;
  logic                        valid;
  logic                        ready;
  logic [frx_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frx_out_if;
  logic                          valid;
  logic                          ready;
  logic [frx_pkg::STATUS_W-1:0]  status;
  logic [frx_pkg::BYTE_W-1:0]    data_byte;
  logic [frx_pkg::IDX_W-1:0]     byte_index;
  logic                          last;
  logic [frx_pkg::COUNT_W-1:0]   good_frames;
  logic [frx_pkg::COUNT_W-1:0]   bad_frames;

  modport source (output valid, output status, output data_byte, output byte_index,
                  output last, output good_frames, output bad_frames, input ready);
  modport sink   (input valid, input status, input data_byte, input byte_index,
                  input last, input good_frames, input bad_frames, output ready);
endinterface

`default_nettype wire

### hw/rtl/frx_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module frx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/frx_parser.sv
// Byte parser: marker registers, frame flags, fill count and store writes.
// Depends on frx_pkg and frx_if; raises a frame request to the readout sequencer.
`default_nettype none

module frx_parser #(
  parameter int unsigned STORE_DEPTH = frx_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [frx_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [frx_pkg::BYTE_W-1:0]           cfg_data,
  frx_in_if.sink                                    rx,
  input  wire logic                                 busy,
  output logic                                      we,
  output logic [$clog2(STORE_DEPTH)-1:0]            waddr,
  output logic [frx_pkg::BYTE_W-1:0]                wdata,
  output frx_pkg::frame_req_t                       req
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  logic [frx_pkg::BYTE_W-1:0] start_char;
  logic [frx_pkg::BYTE_W-1:0] check_char;
  logic [frx_pkg::BYTE_W-1:0] end_char;
  logic [CW-1:0]              fill;
  logic [CW-1:0]              fill_next;
  logic                       start_seen;
  logic                       start_seen_next;
  logic                       check_seen;
  logic                       check_seen_next;
  logic                       accept;
  logic                       room;
  logic                       is_start;
  logic                       is_check;
  logic                       is_end;
  logic [CW-1:0]              fill_push;

  // Hold input while a frame is being read out
  assign rx.ready = !busy;
  assign accept   = rx.valid && !busy;
  assign room     = fill < CW'(STORE_DEPTH);
  assign fill_push = room ? fill + CW'(1) : fill;

  // Classify the byte; start wins, then check, then end
  always_comb begin
    is_start = 1'b0;
    is_check = 1'b0;
    is_end   = 1'b0;
    priority if (rx.rx_byte == start_char) begin
      is_start = 1'b1;
    end else if (start_seen && rx.rx_byte == check_char) begin
      is_check = 1'b1;
    end else if (check_seen && rx.rx_byte == end_char) begin
      is_end = 1'b1;
    end
  end

  // Next flags and fill count
  always_comb begin
    fill_next       = fill;
    start_seen_next = start_seen;
    check_seen_next = check_seen;
    if (accept) begin
      priority if (is_start) begin
        start_seen_next = 1'b1;
        fill_next       = CW'(1);
      end else if (is_check) begin
        check_seen_next = 1'b1;
        fill_next       = fill_push;
      end else if (is_end) begin
        start_seen_next = 1'b0;
        check_seen_next = 1'b0;
        fill_next       = '0;
      end else begin
        fill_next = fill_push;
      end
    end
  end

  // Store write: a start byte always lands at entry zero
  assign we    = accept && (is_start || room);
  assign waddr = is_start ? '0 : fill[AW-1:0];
  assign wdata = rx.rx_byte;

  // Frame request carries the count after the end byte is stored or dropped
  assign req = '{valid: accept && !is_start && !is_check && is_end,
                 fill:  frx_pkg::FILL_MAX_W'(fill_push)};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= frx_pkg::START_CHAR_RST;
      check_char <= frx_pkg::CHECK_CHAR_RST;
      end_char   <= frx_pkg::END_CHAR_RST;
      fill       <= '0;
      start_seen <= 1'b0;
      check_seen <= 1'b0;
    end else begin
      fill       <= fill_next;
      start_seen <= start_seen_next;
      check_seen <= check_seen_next;
      // Register writes; unknown indexes are dropped
      if (cfg_we) begin
        unique case (cfg_index)
          frx_pkg::REG_START_CHAR: start_char <= cfg_data;
          frx_pkg::REG_CHECK_CHAR: check_char <= cfg_data;
          frx_pkg::REG_END_CHAR:   end_char   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/frx_seq.sv
// Readout sequencer: length check, XOR pass, payload emission from the store and error items.
// Depends on frx_pkg and frx_if; reads the store through the RAM read port.
`default_nettype none

module frx_seq #(
  parameter int unsigned STORE_DEPTH = frx_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire frx_pkg::frame_req_t                  req,
  input  wire logic [frx_pkg::BYTE_W-1:0]           rdata,
  output logic [$clog2(STORE_DEPTH)-1:0]            raddr,
  output logic                                      busy,
  frx_out_if.source                                 result
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  frx_pkg::seq_state_t         state;
  frx_pkg::seq_state_t         state_next;
  frx_pkg::status_t            err_code;
  logic [CW-1:0]               n_r;
  logic [CW-1:0]               len_r;
  logic [CW-1:0]               cnt;
  logic [frx_pkg::BYTE_W-1:0]  x;
  logic                        rd_vld;
  logic [frx_pkg::COUNT_W-1:0] good_count;
  logic [frx_pkg::COUNT_W-1:0] bad_count;

  logic                        out_valid;
  frx_pkg::status_t            out_status;
  logic [frx_pkg::BYTE_W-1:0]  out_data;
  logic [frx_pkg::IDX_W-1:0]   out_idx;
  logic                        out_last;
  logic [frx_pkg::COUNT_W-1:0] out_good;
  logic [frx_pkg::COUNT_W-1:0] out_bad;

  logic                        slot_free;
  logic                        short_frame;
  logic                        len_bad;
  logic                        xor_more;
  logic                        load_data;
  logic                        load_err;

  assign slot_free   = !out_valid || result.ready;
  assign short_frame = req.fill < frx_pkg::FILL_MAX_W'(2);
  assign len_bad     = ({1'b0, rdata} + 9'd5) > 9'(n_r);
  assign xor_more    = cnt < len_r;
  assign busy        = state != frx_pkg::S_IDLE;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      frx_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = short_frame ? frx_pkg::S_ERR : frx_pkg::S_LEN;
        end
      end
      frx_pkg::S_LEN:    state_next = frx_pkg::S_LENCHK;
      frx_pkg::S_LENCHK: state_next = len_bad ? frx_pkg::S_ERR : frx_pkg::S_XOR;
      frx_pkg::S_XOR: begin
        if (!xor_more) begin
          state_next = frx_pkg::S_CMP;
        end
      end
      frx_pkg::S_CMP: begin
        priority if (x != rdata) begin
          state_next = frx_pkg::S_ERR;
        end else if (len_r == '0) begin
          state_next = frx_pkg::S_IDLE;
        end else begin
          state_next = frx_pkg::S_RD;
        end
      end
      frx_pkg::S_RD: state_next = frx_pkg::S_OUT;
      frx_pkg::S_OUT: begin
        if (slot_free) begin
          state_next = (cnt + CW'(1) == len_r) ? frx_pkg::S_IDLE : frx_pkg::S_RD;
        end
      end
      frx_pkg::S_ERR: begin
        if (slot_free) begin
          state_next = frx_pkg::S_IDLE;
        end
      end
      default: state_next = frx_pkg::S_IDLE;
    endcase
  end

  // Read address and output loads
  always_comb begin
    raddr     = '0;
    load_data = 1'b0;
    load_err  = 1'b0;
    unique case (state)
      frx_pkg::S_LEN: raddr = AW'(1);
      frx_pkg::S_XOR: raddr = xor_more ? AW'(cnt + CW'(2)) : AW'(len_r + CW'(3));
      frx_pkg::S_RD:  raddr = AW'(cnt + CW'(2));
      frx_pkg::S_OUT: begin
        raddr     = AW'(cnt + CW'(2));
        load_data = slot_free;
      end
      frx_pkg::S_ERR: load_err = slot_free;
      default: raddr = '0;
    endcase
  end

  // Control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= frx_pkg::S_IDLE;
      rd_vld     <= 1'b0;
      good_count <= '0;
      bad_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == frx_pkg::S_XOR) && xor_more;
      if (load_data || load_err) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if ((state == frx_pkg::S_IDLE && req.valid && short_frame) ||
          (state == frx_pkg::S_LENCHK && len_bad) ||
          (state == frx_pkg::S_CMP && x != rdata)) begin
        bad_count <= bad_count + 1'b1;
      end
      if (state == frx_pkg::S_CMP && x == rdata) begin
        good_count <= good_count + 1'b1;
      end
    end
  end

  // Frame working registers and output payload
  always_ff @(posedge clk) begin
    unique case (state)
      frx_pkg::S_IDLE: begin
        n_r      <= req.fill[CW-1:0];
        err_code <= frx_pkg::ST_LEN;
      end
      frx_pkg::S_LENCHK: begin
        len_r <= rdata[CW-1:0];
        cnt   <= '0;
        x     <= '0;
      end
      frx_pkg::S_XOR: begin
        if (rd_vld) begin
          x <= x ^ rdata;
        end
        if (xor_more) begin
          cnt <= cnt + CW'(1);
        end
      end
      frx_pkg::S_CMP: begin
        cnt      <= '0;
        err_code <= frx_pkg::ST_CSUM;
      end
      frx_pkg::S_OUT: begin
        if (slot_free) begin
          cnt <= cnt + CW'(1);
        end
      end
      default: ;
    endcase
    if (load_data) begin
      out_status <= frx_pkg::ST_DATA;
      out_data   <= rdata;
      out_idx    <= frx_pkg::IDX_W'(cnt);
      out_last   <= cnt + CW'(1) == len_r;
      out_good   <= good_count;
      out_bad    <= bad_count;
    end else if (load_err) begin
      out_status <= err_code;
      out_data   <= '0;
      out_idx    <= '0;
      out_last   <= 1'b1;
      out_good   <= good_count;
      out_bad    <= bad_count;
    end
  end

  assign result.valid       = out_valid;
  assign result.status      = out_status;
  assign result.data_byte   = out_data;
  assign result.byte_index  = out_idx;
  assign result.last        = out_last;
  assign result.good_frames = out_good;
  assign result.bad_frames  = out_bad;

endmodule

`default_nettype wire

### hw/rtl/delimited_frame_receiver_xor_check.sv
// Delimited frame receiver with XOR check.
// Channels: rx takes one received byte per transfer; result gives payload bytes with a
// last mark, or a single error item, along with the good and bad frame counts.
// Configuration: cfg_we / cfg_index / cfg_data set the start, check and end markers;
// write them only while the block is idle.
// Every byte, markers included, is written into the frame store (one RAM with a
// registered read port) at the cycle of its transfer while the store has room (a
// start byte always is); outside a frame end rx takes one byte per cycle. After an
// end byte that closes a frame, rx.ready drops while the readout sequencer reads the
// length, runs the XOR over the payload one entry per cycle and compares the
// checksum, ending with an error item at the first failed check; on a match it reads
// each payload byte and loads it into the output register once free. rx.ready returns
// once the sequencer is idle; a result stall holds it low while that register is full.
// A single output register sits on result, so a finished item may wait there while
// rx takes bytes. Reset (rst, synchronous) restores the default markers, clears the
// flags, fill count and frame counts; store contents are not cleared.
`default_nettype none

module delimited_frame_receiver_xor_check #(
  parameter int unsigned STORE_DEPTH = frx_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [frx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [frx_pkg::BYTE_W-1:0]    cfg_data,
  frx_in_if.sink                             rx,
  frx_out_if.source                          result
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [frx_pkg::BYTE_W-1:0] wdata;
  logic [AW-1:0]              raddr;
  logic [frx_pkg::BYTE_W-1:0] rdata;
  logic                       busy;
  frx_pkg::frame_req_t        req;

  frx_parser #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rx       (rx),
    .busy     (busy),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .req      (req)
  );

  frx_ram #(
    .WIDTH(frx_pkg::BYTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  frx_seq #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rdata),
    .raddr (raddr),
    .busy  (busy),
    .result(result)
  );

`ifndef SYNTHESIS
  // A frame request only comes with a byte transfer
  a_req_on_transfer: assert property (@(posedge clk) disable iff (rst)
    req.valid |-> (rx.valid && rx.ready))
    else $error("frame request without a byte transfer");

  // A frame request starts the readout
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid |=> busy)
    else $error("frame request did not start readout");

  // No store write while the sequencer reads the store
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !we)
    else $error("store written during readout");

  // Error items are always the final item of a frame
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != frx_pkg::ST_DATA) |-> result.last)
    else $error("error item without last mark");
`endif

endmodule

`default_nettype wire

### dv/frx_checker.sv
// Result checker for the delimited frame receiver: tracks rx and config transfers,
// predicts the result items of each frame and compares them with the result channel.
// Depends on frx_pkg and the frx_in_if / frx_out_if channel interfaces.
`default_nettype none

module frx_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [frx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [frx_pkg::BYTE_W-1:0]    cfg_data,
  frx_in_if                                  rx,
  frx_out_if                                 result,
  output int                                 errors,
  output int                                 pending
);
  import frx_pkg::*;

  localparam int DEPTH = STORE_DEPTH_DEF;

  typedef struct packed {
    status_t            status;
    logic [BYTE_W-1:0]  data_byte;
    logic [IDX_W-1:0]   byte_index;
    logic               last;
    logic [COUNT_W-1:0] good_frames;
    logic [COUNT_W-1:0] bad_frames;
  } frame_result_t;

  frame_result_t     due_results[$];
  int                err_count = 0;
  int                due_count = 0;

  // Shadow of the receiver state
  logic [BYTE_W-1:0]  frame_bytes [DEPTH];
  int                 fill;
  bit                 start_seen;
  bit                 check_seen;
  logic [COUNT_W-1:0] good_total;
  logic [COUNT_W-1:0] bad_total;
  logic [BYTE_W-1:0]  start_mark;
  logic [BYTE_W-1:0]  check_mark;
  logic [BYTE_W-1:0]  end_mark;

  assign errors  = err_count;
  assign pending = due_count;

  // Append a byte; drop it once the store is full
  function automatic void store_byte(input logic [BYTE_W-1:0] b);
    if (fill < DEPTH) begin
      frame_bytes[fill] = b;
      fill++;
    end
  endfunction

  // Validate the completed frame and queue the items it produces
  task automatic close_frame();
    int                n;
    int                len;
    logic [BYTE_W-1:0] sum;
    frame_result_t     r;
    n   = fill;
    sum = '0;
    r   = '{status: ST_LEN, data_byte: '0, byte_index: '0, last: 1'b1,
            good_frames: '0, bad_frames: '0};
    // a store with fewer than two bytes has no length field: treat as bad length
    len = (n < 2) ? n : int'(frame_bytes[1]);
    if (len + 5 > n) begin
      bad_total++;
      r.good_frames = good_total;
      r.bad_frames  = bad_total;
      due_results.push_back(r);
    end else begin
      for (int i = 0; i < len; i++) sum ^= frame_bytes[(2 + i) % DEPTH];
      if (sum != frame_bytes[(len + 3) % DEPTH]) begin
        bad_total++;
        r.status      = ST_CSUM;
        r.good_frames = good_total;
        r.bad_frames  = bad_total;
        due_results.push_back(r);
      end else begin
        good_total++;
        for (int i = 0; i < len; i++) begin
          r.status      = ST_DATA;
          r.data_byte   = frame_bytes[(2 + i) % DEPTH];
          r.byte_index  = i[IDX_W-1:0];
          r.last        = (i + 1 == len);
          r.good_frames = good_total;
          r.bad_frames  = bad_total;
          due_results.push_back(r);
        end
      end
    end
  endtask

  // Advance the parser by one received byte
  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
    if (b == start_mark) begin
      start_seen = 1'b1;
      fill       = 0;
      store_byte(b);
    end else if (start_seen && b == check_mark) begin
      check_seen = 1'b1;
      store_byte(b);
    end else if (check_seen && b == end_mark) begin
      start_seen = 1'b0;
      check_seen = 1'b0;
      store_byte(b);
      close_frame();
      fill = 0;
    end else begin
      store_byte(b);
    end
  endtask

  // Compare one result transfer with the oldest queued item
  task automatic check_result();
    frame_result_t got;
    frame_result_t want;
    got.status      = status_t'(result.status);
    got.data_byte   = result.data_byte;
    got.byte_index  = result.byte_index;
    got.last        = result.last;
    got.good_frames = result.good_frames;
    got.bad_frames  = result.bad_frames;
    if (due_results.size() == 0) begin
      err_count++;
      $display("%0t: unexpected result: status=%0d data=%02h index=%0d last=%0b good=%0d bad=%0d",
               $time, got.status, got.data_byte, got.byte_index, got.last,
               got.good_frames, got.bad_frames);
    end else begin
      want = due_results.pop_front();
      if (got !== want) begin
        err_count++;
        $display("%0t: result mismatch: expected status=%0d data=%02h index=%0d last=%0b good=%0d bad=%0d",
                 $time, want.status, want.data_byte, want.byte_index, want.last,
                 want.good_frames, want.bad_frames);
        $display("%0t:                  actual   status=%0d data=%02h index=%0d last=%0b good=%0d bad=%0d",
                 $time, got.status, got.data_byte, got.byte_index, got.last,
                 got.good_frames, got.bad_frames);
      end
    end
  endtask

  // Sample every transfer at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      fill       = 0;
      start_seen = 1'b0;
      check_seen = 1'b0;
      good_total = '0;
      bad_total  = '0;
      start_mark = START_CHAR_RST;
      check_mark = CHECK_CHAR_RST;
      end_mark   = END_CHAR_RST;
      due_results.delete();
    end else begin
      if (result.valid && result.ready) check_result();
      if (rx.valid && rx.ready) parse_rx_byte(rx.rx_byte);
      if (cfg_we) begin
        case (cfg_index)
          REG_START_CHAR: start_mark = cfg_data;
          REG_CHECK_CHAR: check_mark = cfg_data;
          REG_END_CHAR:   end_mark   = cfg_data;
          default: ;
        endcase
      end
    end
    due_count = due_results.size();
  end

endmodule

`default_nettype wire

### dv/testbench.sv
// Top of the frame receiver test: clock, reset, marker setup and byte stimulus with
// random idling on both channels; the verdict comes from frx_checker's failure and pending counts.
// Depends on frx_pkg, the channel interfaces, frx_checker and the receiver RTL.
`default_nettype none

module testbench;
  import frx_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 250;
  localparam int PHASE_BYTES  = 75;

  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_BAD_LEN,
    FR_OVERFLOW,
    FR_REARM,
    FR_TRUNC
  } frame_kind_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;
  int                   errors;
  int                   pending;
  int                   cycles = 0;
  int                   sent_bytes = 0;
  int                   rx_gap_pct = 0;
  int                   stall_pct = 0;
  logic [BYTE_W-1:0]    mk_start = START_CHAR_RST;
  logic [BYTE_W-1:0]    mk_check = CHECK_CHAR_RST;
  logic [BYTE_W-1:0]    mk_end   = END_CHAR_RST;

  frx_in_if  rx_ch ();
  frx_out_if res_ch ();

  delimited_frame_receiver_xor_check u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_ch),
    .result    (res_ch)
  );

  frx_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_ch),
    .result    (res_ch),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL delimited_frame_receiver_xor_check");
      $finish;
    end
  end

  // Result side: stall in random bursts
  initial begin
    int stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(15);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one byte, with an optional idle burst first, and hold it until transfer
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (rx_gap_pct > 0 && $urandom_range(99) < rx_gap_pct) begin
      gap = $urandom_range(16, 1);
      rx_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    sent_bytes++;
    @(negedge clk);
  endtask

  // Wait until every queued item has arrived, then idle for the sequencer to go quiet
  task automatic drain();
    rx_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Load all three markers on consecutive cycles
  task automatic set_markers(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] c,
                             input logic [BYTE_W-1:0] e);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_CHAR;
    cfg_data  <= s;
    @(negedge clk);
    cfg_index <= REG_CHECK_CHAR;
    cfg_data  <= c;
    @(negedge clk);
    cfg_index <= REG_END_CHAR;
    cfg_data  <= e;
    @(negedge clk);
    cfg_we   <= 1'b0;
    mk_start = s;
    mk_check = c;
    mk_end   = e;
  endtask

  task automatic set_random_markers();
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] e;
    s = $urandom_range(255);
    do c = $urandom_range(255); while (c == s);
    do e = $urandom_range(255); while (e == s || e == c);
    set_markers(s, c, e);
  endtask

  function automatic bit is_marker(input logic [BYTE_W-1:0] b);
    return b == mk_start || b == mk_check || b == mk_end;
  endfunction

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = $urandom_range(255); while (is_marker(b));
    return b;
  endfunction

  // Send one frame of the given kind around a payload of len bytes
  task automatic send_frame(input frame_kind_t kind, input int len);
    logic [BYTE_W-1:0] body[$];
    logic [BYTE_W-1:0] sum;
    int                tries;
    sum = '0;
    for (int i = 0; i < len; i++) begin
      body.push_back(plain_byte());
      sum ^= body[i];
    end
    // try to keep the checksum of a good frame clear of the markers
    tries = 0;
    while (kind == FR_GOOD && len > 0 && is_marker(sum) && tries < 8) begin
      sum ^= body[len-1];
      body[len-1] = plain_byte();
      sum ^= body[len-1];
      tries++;
    end
    if (kind == FR_BAD_SUM) sum ^= 8'($urandom_range(255, 1));
    // open a frame and arm the check flag so the real start lands while armed
    if (kind == FR_REARM) begin
      send_byte(mk_start);
      send_byte(8'($urandom_range(255)));
      repeat ($urandom_range(3)) send_byte(plain_byte());
      send_byte(mk_check);
    end
    send_byte(mk_start);
    if (kind == FR_BAD_LEN) send_byte(8'(len + $urandom_range(20, 1)));
    else send_byte(8'(len));
    foreach (body[i]) send_byte(body[i]);
    if (kind == FR_OVERFLOW) begin
      repeat ($urandom_range(20, 1)) send_byte(plain_byte());
    end
    if (kind == FR_TRUNC) return;
    send_byte(mk_check);
    send_byte(sum);
    send_byte(mk_end);
  endtask

  // Pick a frame shape; mostly well-formed with short payloads
  task automatic random_frame();
    int          roll;
    int          len;
    frame_kind_t kind;
    roll = $urandom_range(99);
    if (roll < 56)      kind = FR_GOOD;
    else if (roll < 68) kind = FR_BAD_SUM;
    else if (roll < 77) kind = FR_BAD_LEN;
    else if (roll < 82) kind = FR_OVERFLOW;
    else if (roll < 91) kind = FR_REARM;
    else                kind = FR_TRUNC;
    if (kind == FR_OVERFLOW)          len = $urandom_range(59, 45);
    else if ($urandom_range(99) < 85) len = $urandom_range(8);
    else                              len = $urandom_range(59, 9);
    if (kind == FR_GOOD) begin
      while (is_marker(8'(len))) len = $urandom_range(8);
    end
    // stray bytes between frames, markers included
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
    end
    send_frame(kind, len);
  endtask

  task automatic run_phase(input int gap_pct, input int hold_pct);
    int target;
    target     = sent_bytes + PHASE_BYTES;
    rx_gap_pct = gap_pct;
    stall_pct  = hold_pct;
    while (sent_bytes < target) random_frame();
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_START_CHAR;
    cfg_data      = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames with the reset markers
    rx_gap_pct = 20;
    stall_pct  = 20;
    // good frame with extreme payload bytes
    send_byte(mk_start); send_byte(8'h02); send_byte(8'h00); send_byte(8'hFF);
    send_byte(mk_check); send_byte(8'hFF); send_byte(mk_end);
    // empty payload: counts as good, produces no item
    send_byte(mk_start); send_byte(8'h00); send_byte(mk_check); send_byte(8'h00);
    send_byte(mk_end);
    // checksum mismatch
    send_byte(mk_start); send_byte(8'h01); send_byte(8'h5A); send_byte(mk_check);
    send_byte(8'h00); send_byte(mk_end);
    // length beyond the stored bytes
    send_byte(mk_start); send_byte(8'h09); send_byte(mk_check); send_byte(8'h00);
    send_byte(mk_end);

    // Random frames across marker settings and idle patterns
    run_phase(30, 30);
    drain();
    set_markers(8'h00, 8'hFF, 8'h80);
    run_phase(40, 0);
    drain();
    set_markers(8'hFF, 8'h00, 8'h7F);
    run_phase(0, 40);
    drain();
    set_random_markers();
    run_phase(15, 15);
    drain();
    set_markers(START_CHAR_RST, CHECK_CHAR_RST, END_CHAR_RST);
    run_phase(50, 50);
    drain();
    set_random_markers();
    run_phase(0, 0);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("PASS delimited_frame_receiver_xor_check");
    end else begin
      $display("FAIL delimited_frame_receiver_xor_check");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/frx_pkg.sv
hw/rtl/frx_if.sv
hw/rtl/frx_ram.sv
hw/rtl/frx_parser.sv
hw/rtl/frx_seq.sv
hw/rtl/delimited_frame_receiver_xor_check.sv
dv/frx_checker.sv
dv/testbench.sv
